[design/sdp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdp_pkg
// Shared types and constants for the structured-data parser: token kinds,
// character codes, result and queue record layouts.
// ----------------------------------------------------------------------------
package sdp_pkg;

  localparam int ByteWidth  = 8;
  localparam int KindWidth  = 3;
  localparam int LenWidth   = 8;
  localparam int CountWidth = 10;

  localparam logic [CountWidth-1:0] ValueCapReset = 10'd1023;

  // Default depth of the queue between parser and serializer
  localparam int QueueDepthDefault = 4;

  // Token kinds
  localparam logic [KindWidth-1:0] KIND_ELEM_START = 3'd0;
  localparam logic [KindWidth-1:0] KIND_ID_CHAR    = 3'd1;
  localparam logic [KindWidth-1:0] KIND_NAME_CHAR  = 3'd2;
  localparam logic [KindWidth-1:0] KIND_VALUE_CHAR = 3'd3;
  localparam logic [KindWidth-1:0] KIND_PAIR_END   = 3'd4;

  // Characters the parser reacts to
  localparam logic [ByteWidth-1:0] CH_OPEN    = 8'h5B; // [
  localparam logic [ByteWidth-1:0] CH_CLOSE   = 8'h5D; // ]
  localparam logic [ByteWidth-1:0] CH_SPACE   = 8'h20;
  localparam logic [ByteWidth-1:0] CH_AT      = 8'h40; // @
  localparam logic [ByteWidth-1:0] CH_EQUAL   = 8'h3D; // =
  localparam logic [ByteWidth-1:0] CH_QUOTE   = 8'h22; // "
  localparam logic [ByteWidth-1:0] CH_BSLASH  = 8'h5C; // backslash

  // Lengths of the two matched words
  localparam logic [LenWidth-1:0] OriginLen = 8'd6;
  localparam logic [LenWidth-1:0] IpLen     = 8'd2;
  localparam logic [LenWidth-1:0] LenMax    = 8'd255;
  localparam logic [LenWidth:0]   KeyLimit  = 9'd248;

  // One result token
  typedef struct packed {
    logic [KindWidth-1:0]  kind;
    logic [ByteWidth-1:0]  tbyte;
    logic                  origin_ip;
    logic                  fits;
    logic [CountWidth-1:0] vlen;
    logic                  last;
  } sdp_result_t;

  // All results caused by one input byte
  typedef struct packed {
    logic        two;
    sdp_result_t r0;
    sdp_result_t r1;
  } sdp_record_t;

  // Character of "origin" at a position below six
  function automatic logic [ByteWidth-1:0] origin_char(input logic [2:0] pos);
    logic [ByteWidth-1:0] ch;
    case (pos)
      3'd0:    ch = 8'h6F; // o
      3'd1:    ch = 8'h72; // r
      3'd2:    ch = 8'h69; // i
      3'd3:    ch = 8'h67; // g
      3'd4:    ch = 8'h69; // i
      3'd5:    ch = 8'h6E; // n
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Character of "ip" at a position below two
  function automatic logic [ByteWidth-1:0] ip_char(input logic pos);
    return pos ? 8'h70 : 8'h69;
  endfunction

endpackage

[design/sdp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdp_front
// Parser front end: takes one byte per beat, advances the parse state and
// builds the record of up to two tokens that the byte causes.
// ----------------------------------------------------------------------------
module sdp_front
  import sdp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_room,
  input  logic [ByteWidth-1:0]  in_byte,
  input  logic                  in_eos,
  input  logic [CountWidth-1:0] value_cap,
  output logic                  push,
  output sdp_record_t           push_rec
);

  localparam logic [2:0] PH_SEEK   = 3'd0;
  localparam logic [2:0] PH_ID     = 3'd1;
  localparam logic [2:0] PH_GAP    = 3'd2;
  localparam logic [2:0] PH_NAME   = 3'd3;
  localparam logic [2:0] PH_QUOTE  = 3'd4;
  localparam logic [2:0] PH_VALUE  = 3'd5;
  localparam logic [2:0] PH_ESCAPE = 3'd6;
  localparam logic [2:0] PH_SKIP   = 3'd7;

  logic [2:0]            phase, phase_next;
  logic [LenWidth-1:0]   id_len, id_len_next;
  logic                  at_seen, at_seen_next;
  logic                  id_origin, id_origin_next;
  logic [LenWidth-1:0]   name_len, name_len_next;
  logic                  name_ip, name_ip_next;
  logic [CountWidth-1:0] vcount, vcount_next;

  sdp_result_t res [2];
  logic [1:0]  cnt;
  logic        do_gap, do_name;
  logic [LenWidth-1:0] nbase_len;
  logic        nbase_ip;
  logic        accept;

  assign accept = in_valid && in_room;

  // Single-step parse of one byte, including the re-parse paths
  always_comb begin
    sdp_result_t tok;
    sdp_result_t pend;
    phase_next     = phase;
    id_len_next    = id_len;
    at_seen_next   = at_seen;
    id_origin_next = id_origin;
    name_len_next  = name_len;
    name_ip_next   = name_ip;
    vcount_next    = vcount;
    res[0]         = '0;
    res[1]         = '0;
    cnt            = 2'd0;
    do_gap         = 1'b0;
    do_name        = 1'b0;
    nbase_len      = name_len;
    nbase_ip       = name_ip;

    tok       = '0;
    tok.tbyte = in_byte;

    pend           = '0;
    pend.kind      = KIND_PAIR_END;
    pend.origin_ip = id_origin && (id_len == OriginLen) && name_ip && (name_len == IpLen);
    pend.fits      = ({1'b0, id_len} + {1'b0, name_len}) < KeyLimit;

    unique case (phase)
      PH_SEEK: begin
        if (in_byte == CH_OPEN) begin
          id_len_next    = '0;
          at_seen_next   = 1'b0;
          id_origin_next = 1'b1;
          res[cnt[0]]    = '0;
          cnt            = cnt + 2'd1;
          phase_next     = PH_ID;
        end
      end
      PH_ID: begin
        if (in_byte == CH_SPACE) begin
          phase_next = PH_GAP;
        end else if (in_byte == CH_CLOSE) begin
          phase_next = PH_SEEK;
        end else if (!at_seen) begin
          if (in_byte == CH_AT) begin
            at_seen_next = 1'b1;
          end else begin
            if (id_len >= OriginLen || origin_char(id_len[2:0]) != in_byte) begin
              id_origin_next = 1'b0;
            end
            if (id_len != LenMax) begin
              id_len_next = id_len + 8'd1;
            end
            tok.kind    = KIND_ID_CHAR;
            res[cnt[0]] = tok;
            cnt         = cnt + 2'd1;
          end
        end
      end
      PH_GAP: begin
        do_gap = 1'b1;
      end
      PH_NAME: begin
        do_name = 1'b1;
      end
      PH_QUOTE: begin
        if (in_byte == CH_QUOTE) begin
          vcount_next = '0;
          phase_next  = PH_VALUE;
        end else if (in_byte == CH_CLOSE) begin
          phase_next = PH_SEEK;
        end else begin
          phase_next = PH_SKIP;
        end
      end
      PH_VALUE, PH_ESCAPE: begin
        if (vcount >= value_cap) begin
          pend.vlen   = vcount;
          res[cnt[0]] = pend;
          cnt         = cnt + 2'd1;
          phase_next  = PH_GAP;
          do_gap      = 1'b1;
        end else if (phase == PH_ESCAPE) begin
          tok.kind    = KIND_VALUE_CHAR;
          res[cnt[0]] = tok;
          cnt         = cnt + 2'd1;
          vcount_next = vcount + 10'd1;
          phase_next  = PH_VALUE;
        end else if (in_byte == CH_BSLASH) begin
          phase_next = PH_ESCAPE;
        end else if (in_byte == CH_QUOTE) begin
          pend.vlen   = vcount;
          res[cnt[0]] = pend;
          cnt         = cnt + 2'd1;
          phase_next  = PH_GAP;
        end else begin
          tok.kind    = KIND_VALUE_CHAR;
          res[cnt[0]] = tok;
          cnt         = cnt + 2'd1;
          vcount_next = vcount + 10'd1;
        end
      end
      default: begin
        if (in_byte == CH_CLOSE) begin
          phase_next = PH_SEEK;
        end
      end
    endcase

    // Gap between parameters: a new name starts on any other byte
    if (do_gap) begin
      if (in_byte == CH_CLOSE) begin
        phase_next = PH_SEEK;
      end else if (in_byte != CH_SPACE) begin
        nbase_len     = '0;
        nbase_ip      = 1'b1;
        name_len_next = '0;
        name_ip_next  = 1'b1;
        phase_next    = PH_NAME;
        do_name       = 1'b1;
      end
    end

    // Parameter name character
    if (do_name) begin
      if (in_byte == CH_EQUAL) begin
        phase_next = PH_QUOTE;
      end else if (in_byte == CH_CLOSE) begin
        phase_next = PH_SEEK;
      end else begin
        name_ip_next = nbase_ip;
        if (nbase_len >= IpLen || ip_char(nbase_len[0]) != in_byte) begin
          name_ip_next = 1'b0;
        end
        name_len_next = (nbase_len != LenMax) ? nbase_len + 8'd1 : nbase_len;
        tok.kind      = KIND_NAME_CHAR;
        res[cnt[0]]   = tok;
        cnt           = cnt + 2'd1;
      end
    end

    // End of string: close an open value, then drop back to reset state
    if (in_eos) begin
      if (phase_next == PH_VALUE || phase_next == PH_ESCAPE) begin
        pend.vlen   = vcount_next;
        res[cnt[0]] = pend;
        cnt         = cnt + 2'd1;
      end
      phase_next     = PH_SEEK;
      id_len_next    = '0;
      at_seen_next   = 1'b0;
      id_origin_next = 1'b1;
      name_len_next  = '0;
      name_ip_next   = 1'b1;
      vcount_next    = '0;
    end
  end

  // Build the queue record
  always_comb begin
    push_rec.two     = cnt[1];
    push_rec.r0      = res[0];
    push_rec.r0.last = ~cnt[1];
    push_rec.r1      = res[1];
    push_rec.r1.last = 1'b1;
  end

  assign push = accept && (cnt != 2'd0);

  // Advance parse state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SEEK;
      id_len    <= '0;
      at_seen   <= 1'b0;
      id_origin <= 1'b1;
      name_len  <= '0;
      name_ip   <= 1'b1;
      vcount    <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      id_len    <= id_len_next;
      at_seen   <= at_seen_next;
      id_origin <= id_origin_next;
      name_len  <= name_len_next;
      name_ip   <= name_ip_next;
      vcount    <= vcount_next;
    end
  end

endmodule

[design/sdp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdp_queue
// Short register queue of token records between parser and serializer.
// ----------------------------------------------------------------------------
module sdp_queue
  import sdp_pkg::*;
#(
  parameter int Depth = QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  sdp_record_t push_rec,
  output logic        room,
  input  logic        pop,
  output logic        nonempty,
  output sdp_record_t head
);

  localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] CntFull = CntWidth'(Depth);

  sdp_record_t         slots [Depth];
  logic [PtrWidth-1:0] wr_ptr, rd_ptr;
  logic [CntWidth-1:0] count;

  assign room     = (count != CntFull);
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  // Store pushed records
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + PtrWidth'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + PtrWidth'(1);
      end
      if (push && !pop) begin
        count <= count + CntWidth'(1);
      end else if (pop && !push) begin
        count <= count - CntWidth'(1);
      end
    end
  end

endmodule

[design/sdp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdp_back
// Serializer: unpacks each queued record into one or two output beats and
// holds them in an output register until taken.
// ----------------------------------------------------------------------------
module sdp_back
  import sdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        nonempty,
  input  sdp_record_t head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output sdp_result_t out_res
);

  logic        sub;
  logic        load;
  sdp_result_t pick;

  assign load = nonempty && (!out_valid || out_ready);
  assign pick = sub ? head.r1 : head.r0;
  assign pop  = load && (sub || !head.two);

  // Step through the record
  always_ff @(posedge clk) begin
    if (rst) begin
      sub       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        sub       <= ~pop;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the output beat
  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= pick;
    end
  end

endmodule

[design/syslog_structured_data_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// syslog_structured_data_parser
// Streaming tokenizer for syslog structured data: one input byte per beat,
// element, id, name, value and pair-end tokens out.
// ----------------------------------------------------------------------------
// Path: each token is written into the queue when its byte is taken, and moves on to
// the output register when that register is free.
// Throughput: one byte per cycle while each byte yields at most one token and the
// output is taken; a byte that yields two tokens leaves the single output register
// as two beats in turn. The queue absorbs short bursts of such bytes.
// Reset: synchronous rst clears parse state and queue, value_cap returns to
// 1023.
module syslog_structured_data_parser
  import sdp_pkg::*;
#(
  parameter int QueueDepth = QueueDepthDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // [7:0] data_byte
  input  logic                  s_axis_tlast,  // end_of_string
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] token_byte, [8] is_origin_ip, [9] key_fits, [19:10] value_length, [23:20] zero
  output logic [23:0]           m_axis_tdata,
  output logic [2:0]            m_axis_tuser,  // [2:0] token_kind
  output logic                  m_axis_tlast,  // last_of_run
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CountWidth-1:0] cfg_data       // value_cap
);

  logic [CountWidth-1:0] value_cap;
  logic                  room, push, pop, nonempty;
  sdp_record_t           push_rec, head;
  sdp_result_t           out_res;

  // Value cap register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      value_cap <= ValueCapReset;
    end else if (cfg_valid) begin
      value_cap <= cfg_data;
    end
  end

  assign s_axis_tready = room;

  sdp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_room   (room),
    .in_byte   (s_axis_tdata),
    .in_eos    (s_axis_tlast),
    .value_cap (value_cap),
    .push      (push),
    .push_rec  (push_rec)
  );

  sdp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .room     (room),
    .pop      (pop),
    .nonempty (nonempty),
    .head     (head)
  );

  sdp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .nonempty  (nonempty),
    .head      (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  // Pack the output beat
  assign m_axis_tdata = {4'b0000, out_res.vlen, out_res.fits, out_res.origin_ip, out_res.tbyte};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule
